[src/sem_pkg.sv]
// shared types and constants of the sobel edge magnitude unit
package sem_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int CFG_W          = 11;
	localparam int PIX_W          = 8;
	localparam int MIN_SIZE       = 3;
	localparam int SAT_LIMIT      = 65025;
	localparam int MAG_MAX        = 255;
	localparam int SUM_W          = 22;
	localparam int GRAD_W         = 11;

	// register index, taken from paddr bit 2
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAD,
		ST_SQ1,
		ST_SQ2,
		ST_ROOT,
		ST_FIN
	} sem_state_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic grad;
		logic sq1;
		logic sq2;
		logic root;
		logic load;
	} sem_cmd_t;

	typedef struct packed {
		logic emit;
		logic root_last;
		logic out_busy;
	} sem_sts_t;

endpackage

[src/sem_if.sv]
// stream channel interfaces for pixels and edge results
interface sem_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] gray_pixel;
	modport source (output valid, output op, output gray_pixel, input ready);
	modport sink (input valid, input op, input gray_pixel, output ready);
endinterface

interface sem_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] edge_magnitude;
	logic       frame_end;
	modport source (output valid, output edge_magnitude, output frame_end, input ready);
	modport sink (input valid, input edge_magnitude, input frame_end, output ready);
endinterface

[src/sobel_edge_magnitude_unit.sv]
// top level: apb registers, stream channels, controller and datapath
// an emitting item runs read, gradient, squaring, root search and finish before its result loads
// an item without result returns to idle after read; a new pixel is taken only in idle
// the 8-step bitwise square root search in the datapath sets the item period
// results lag the input stream by one row and one column; width+1 flush items end a frame
// reset: asynchronous active low, clears counters, window and state; sizes return to 1024
module sobel_edge_magnitude_unit #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	sem_in_if.sink      in_ch,
	sem_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [sem_pkg::CFG_W-1:0] width_q, height_q;
	logic                      cfg_wr;
	sem_pkg::sem_cmd_t         cmd;
	sem_pkg::sem_sts_t         sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::CFG_W'(sem_pkg::DEF_MAX_WIDTH);
			height_q <= sem_pkg::CFG_W'(sem_pkg::DEF_MAX_HEIGHT);
		end else if (cfg_wr) begin
			if (paddr[2] == sem_pkg::REG_IMAGE_WIDTH) begin
				width_q <= pwdata[sem_pkg::CFG_W-1:0];
			end else begin
				height_q <= pwdata[sem_pkg::CFG_W-1:0];
			end
		end
	end

	// register read back
	assign prdata = (paddr[2] == sem_pkg::REG_IMAGE_HEIGHT) ? 32'(height_q) : 32'(width_q);

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sem_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.restart        (cfg_wr),
		.cfg_width      (width_q),
		.cfg_height     (height_q),
		.op             (in_ch.op),
		.gray_pixel     (in_ch.gray_pixel),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.edge_magnitude (out_ch.edge_magnitude),
		.frame_end      (out_ch.frame_end)
	);

endmodule

[src/sem_ctrl.sv]
// controller state machine sequencing one item through the datapath
module sem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sem_pkg::sem_sts_t sts,
	output sem_pkg::sem_cmd_t cmd
);

	sem_pkg::sem_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sem_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sem_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = sem_pkg::ST_READ;
				end
			end
			sem_pkg::ST_READ: begin
				cmd.step = 1'b1;
				state_d  = sts.emit ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
			end
			sem_pkg::ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = sem_pkg::ST_SQ1;
			end
			sem_pkg::ST_SQ1: begin
				cmd.sq1 = 1'b1;
				state_d = sem_pkg::ST_SQ2;
			end
			sem_pkg::ST_SQ2: begin
				cmd.sq2 = 1'b1;
				state_d = sem_pkg::ST_ROOT;
			end
			sem_pkg::ST_ROOT: begin
				cmd.root = 1'b1;
				if (sts.root_last) begin
					state_d = sem_pkg::ST_FIN;
				end
			end
			sem_pkg::ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = sem_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sem_pkg::ST_IDLE;
			end
		endcase
	end

	// an accepted transfer always moves on to the store read
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == sem_pkg::ST_READ)
		else $error("accepted item did not enter read");

	// an item without result returns to idle at once
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sem_pkg::ST_READ && !sts.emit) |=> state_q == sem_pkg::ST_IDLE)
		else $error("silent item did not return to idle");

	// a finished result waits while the output register is still held
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sem_pkg::ST_FIN && sts.out_busy) |=> state_q == sem_pkg::ST_FIN)
		else $error("result loaded over a pending output");

endmodule

[src/sem_dp.sv]
// datapath: line stores, window, counters, gradients and iterative root
module sem_dp #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sem_pkg::sem_cmd_t         cmd,
	output sem_pkg::sem_sts_t         sts,
	input  logic                      restart,
	input  logic [sem_pkg::CFG_W-1:0] cfg_width,
	input  logic [sem_pkg::CFG_W-1:0] cfg_height,
	input  logic                      op,
	input  logic [7:0]                gray_pixel,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                edge_magnitude,
	output logic                      frame_end
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 3);
	localparam int SW = sem_pkg::SUM_W;
	localparam int GW = sem_pkg::GRAD_W;

	logic [7:0] upper_mem [MAX_WIDTH];
	logic [7:0] middle_mem [MAX_WIDTH];

	logic [WW-1:0] w_eff, h_cmp_w;
	logic [HW-1:0] h_eff;
	logic [WW-1:0] in_col_q, out_col_q, c_now, c_q, c_next;
	logic [HW-1:0] in_row_q, out_row_q;
	logic [7:0]    px_q, top_q, mid_q;
	logic [7:0]    win_q [9];
	logic          mt_q, mb_q, ml_q, mr_q, last_q, last_now;
	logic signed [GW-1:0] gx_q, gy_q;
	logic [SW-1:0] s_q;
	logic [7:0]    root_q, root_try, mag;
	logic [2:0]    bit_q;
	logic [15:0]   try_sq, root_sq;
	logic signed [2*GW-1:0] gx_sq, gy_sq;
	logic [7:0]    v [9];
	logic [9:0]    gx_pos, gx_neg, gy_pos, gy_neg;
	logic          out_valid_q;

	// clamp the configured sizes to the supported range
	always_comb begin
		if (32'(cfg_width) < 32'(sem_pkg::MIN_SIZE)) begin
			w_eff = WW'(sem_pkg::MIN_SIZE);
		end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_width);
		end
		if (32'(cfg_height) < 32'(sem_pkg::MIN_SIZE)) begin
			h_eff = HW'(sem_pkg::MIN_SIZE);
		end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg_height);
		end
		h_cmp_w = w_eff;
	end

	// column of the incoming item and its successor
	assign c_now  = (in_col_q < w_eff) ? in_col_q : '0;
	assign c_next = c_q + WW'(1);
	assign last_now = (out_row_q + HW'(1) >= h_eff) && (out_col_q + WW'(1) >= h_cmp_w);

	assign sts.emit = (in_row_q >= HW'(2)) || (in_row_q == HW'(1) && c_q >= WW'(1));
	assign sts.root_last = (bit_q == 3'd0);
	assign sts.out_busy  = out_valid_q && !out_ready;

	// line store reads on capture, writes on step
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			top_q <= upper_mem[c_now[AW-1:0]];
			mid_q <= middle_mem[c_now[AW-1:0]];
		end
		if (cmd.step) begin
			upper_mem[c_q[AW-1:0]]  <= mid_q;
			middle_mem[c_q[AW-1:0]] <= px_q;
		end
	end

	// captured pixel and column
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= op ? 8'd0 : gray_pixel;
			c_q  <= c_now;
		end
		if (cmd.step) begin
			mt_q   <= (out_row_q != '0);
			mb_q   <= (out_row_q + HW'(1) < h_eff);
			ml_q   <= (out_col_q != '0);
			mr_q   <= (out_col_q + WW'(1) < w_eff);
			last_q <= last_now;
		end
	end

	// 3x3 window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.step) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= top_q;
			win_q[5] <= mid_q;
			win_q[8] <= px_q;
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cmd.step) begin
			if (sts.emit && last_now) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (c_next >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HW'(1);
				end else begin
					in_col_q <= c_next;
				end
				if (sts.emit) begin
					if (out_col_q + WW'(1) >= w_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HW'(1);
					end else begin
						out_col_q <= out_col_q + WW'(1);
					end
				end
			end
		end
	end

	// masked neighbours and gradient sums
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				v[r*3+k] = ((r == 0 && !mt_q) || (r == 2 && !mb_q) ||
					(k == 0 && !ml_q) || (k == 2 && !mr_q)) ? 8'd0 : win_q[r*3+k];
			end
		end
		gx_pos = 10'(v[2]) + {1'b0, v[5], 1'b0} + 10'(v[8]);
		gx_neg = 10'(v[0]) + {1'b0, v[3], 1'b0} + 10'(v[6]);
		gy_pos = 10'(v[0]) + {1'b0, v[1], 1'b0} + 10'(v[2]);
		gy_neg = 10'(v[6]) + {1'b0, v[7], 1'b0} + 10'(v[8]);
	end

	assign gx_sq    = (2*GW)'(gx_q) * (2*GW)'(gx_q);
	assign gy_sq    = (2*GW)'(gy_q) * (2*GW)'(gy_q);
	assign root_try = root_q | (8'd1 << bit_q);
	assign try_sq   = 16'(root_try) * 16'(root_try);
	assign root_sq  = 16'(root_q) * 16'(root_q);

	// gradients, squared sum and bitwise root search
	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			gx_q <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
			gy_q <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
		end
		if (cmd.sq1) begin
			s_q <= SW'(unsigned'(gx_sq));
		end
		if (cmd.sq2) begin
			s_q    <= s_q + SW'(unsigned'(gy_sq));
			root_q <= '0;
			bit_q  <= 3'd7;
		end
		if (cmd.root) begin
			if (SW'(try_sq) <= s_q) begin
				root_q <= root_try;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	// ceiling and saturation
	always_comb begin
		if (s_q > SW'(sem_pkg::SAT_LIMIT)) begin
			mag = 8'(sem_pkg::MAG_MAX);
		end else if (SW'(root_sq) < s_q) begin
			mag = root_q + 8'd1;
		end else begin
			mag = root_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			edge_magnitude <= mag;
			frame_end      <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
